// ===== rtl/pic_pkg.sv =====
// Package for the pulse input counter request block.
// Holds the pulse id codes, the channel 13 masks, the request codes and shared types.
// No dependencies.
`default_nettype none

package pic_pkg;

  // Pulse source codes
  localparam logic [4:0] PidAngleLast   = 5'd9;
  localparam logic [4:0] PidAccelFirst  = 5'd10;
  localparam logic [4:0] PidAccelLast   = 5'd15;
  localparam logic [4:0] PidUplinkLast  = 5'd17;
  localparam logic [4:0] PidXlinkLast   = 5'd19;
  localparam logic [4:0] PidLrLast      = 5'd21;
  localparam logic [4:0] PidRrLast      = 5'd23;
  localparam logic [4:0] PidDownlinkEnd = 5'd26;

  // Channel 13 bit masks
  localparam logic [5:0] C13RrSel   = 6'o03;
  localparam logic [5:0] C13LrBoth  = 6'o14;
  localparam logic [5:0] C13RadarEn = 6'o10;
  localparam logic [5:0] C13Xlink   = 6'o20;
  localparam logic [5:0] C13Inhibit = 6'o40;

  // Counter selects
  localparam logic [3:0] SelAccelBase = 4'd5;
  localparam logic [3:0] SelInlink    = 4'd8;
  localparam logic [3:0] SelRadar     = 4'd9;

  // Accelerometer precounter limits
  localparam logic [1:0] PcTop    = 2'd3;
  localparam logic [1:0] PcBottom = 2'd0;

  localparam int unsigned NumAxes = 3;

  typedef enum logic [1:0] {
    KindPlus  = 2'd0,
    KindMinus = 2'd1,
    KindOne   = 2'd2,
    KindZero  = 2'd3
  } count_kind_e;

  // One 2-bit precounter per accel axis
  typedef logic [NumAxes-1:0][1:0] precount_t;

  typedef struct packed {
    logic [4:0] pulse_id;
    logic [5:0] chan13_bits;
    logic       uplink_enable;
    logic       uplink_too_fast;
  } pulse_t;

  typedef struct packed {
    logic        count_valid;
    logic [3:0]  counter_sel;
    count_kind_e count_kind;
    logic        clear_ch33;
    logic        downrupt_request;
    logic [1:0]  accel_seen_axis;
    logic        accel_seen_minus;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/pulse_input_counter_requests.sv =====
// Top level of the pulse input counter request block: input register, decode, result register.
// Depends on pic_pkg and pic_decode.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+--------------------------------------------------
//   in      | in_valid_i / in_ready_o   | pulse_id_i, chan13_bits_i, uplink_enable_i,
//           |                           | uplink_too_fast_i
//   out     | out_valid_o / out_ready_i | count_valid_o, counter_sel_o, count_kind_o,
//           |                           | clear_ch33_o, downrupt_request_o,
//           |                           | accel_seen_axis_o, accel_seen_minus_o
//
// One transfer per cycle in and out unless the output stalls; a pulse is registered at input and at output.
// The accel precounters are read and updated in the decode step, one pulse a cycle unless the output stalls.
// Reset clears the precounters and both stage valid flags.
// A stalled output holds its result; the input register keeps filling until both stages are full.
`default_nettype none

module pulse_input_counter_requests (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [4:0] pulse_id_i,
  input  wire logic [5:0] chan13_bits_i,
  input  wire logic       uplink_enable_i,
  input  wire logic       uplink_too_fast_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            count_valid_o,
  output logic [3:0]      counter_sel_o,
  output logic [1:0]      count_kind_o,
  output logic            clear_ch33_o,
  output logic            downrupt_request_o,
  output logic [1:0]      accel_seen_axis_o,
  output logic            accel_seen_minus_o
);

  logic               in_valid_q;
  pic_pkg::pulse_t    pulse_q;
  logic               out_valid_q;
  pic_pkg::result_t   result_q;
  pic_pkg::result_t   result_d;
  pic_pkg::precount_t precount_q;
  pic_pkg::precount_t precount_d;
  logic               out_adv;
  logic               in_adv;

  // Stage handshakes
  assign out_adv    = !out_valid_q || out_ready_i;
  assign in_adv     = in_valid_q && out_adv;
  assign in_ready_o = !in_valid_q || out_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pulse_q <= '{pulse_id:        pulse_id_i,
                   chan13_bits:     chan13_bits_i,
                   uplink_enable:   uplink_enable_i,
                   uplink_too_fast: uplink_too_fast_i};
    end
  end

  pic_decode u_decode (
    .pulse_i    (pulse_q),
    .precount_i (precount_q),
    .result_o   (result_d),
    .precount_o (precount_d)
  );

  // Precounters step when the decoded pulse moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precount_q <= '0;
    end else if (in_adv) begin
      precount_q <= precount_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign count_valid_o      = result_q.count_valid;
  assign counter_sel_o      = result_q.counter_sel;
  assign count_kind_o       = result_q.count_kind;
  assign clear_ch33_o       = result_q.clear_ch33;
  assign downrupt_request_o = result_q.downrupt_request;
  assign accel_seen_axis_o  = result_q.accel_seen_axis;
  assign accel_seen_minus_o = result_q.accel_seen_minus;

  // A channel 33 clear never comes with a counter request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(clear_ch33_o && count_valid_o))
    else $error("clear_ch33 raised together with a counter request");

  // An accel request always names the axis that was pulsed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && count_valid_o && counter_sel_o >= pic_pkg::SelAccelBase
     && counter_sel_o < pic_pkg::SelInlink)
    |-> (accel_seen_axis_o == 2'(counter_sel_o - pic_pkg::SelAccelBase + 4'd1)))
    else $error("accel request does not match the pulsed axis");

  // Precounters only move when a pulse passes through decode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(precount_q) |-> $past(in_adv))
    else $error("precounter changed without a decoded pulse");

  // A result register that is stalled keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(result_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== rtl/pic_decode.sv =====
// Combinational decode of one pulse: gating, request select and precounter step.
// Depends on pic_pkg.
`default_nettype none

module pic_decode (
  input  pic_pkg::pulse_t    pulse_i,
  input  pic_pkg::precount_t precount_i,
  output pic_pkg::result_t   result_o,
  output pic_pkg::precount_t precount_o
);

  logic [4:0]           id;
  logic [5:0]           c13;
  logic                 odd;
  pic_pkg::count_kind_e link_kind;
  logic [4:0]           accel_off;
  logic [1:0]           axis;
  logic [1:0]           pc;
  logic                 link_adm;
  logic                 link_pulse;

  assign id        = pulse_i.pulse_id;
  assign c13       = pulse_i.chan13_bits;
  assign odd       = id[0];
  assign link_kind = odd ? pic_pkg::KindZero : pic_pkg::KindOne;
  assign accel_off = id - pic_pkg::PidAccelFirst;
  assign axis      = accel_off[2:1];
  assign pc        = precount_i[axis];

  // Link admission: uplink needs enable and uplink select, crosslink needs its select
  always_comb begin
    link_pulse = 1'b0;
    link_adm   = 1'b0;
    if (id > pic_pkg::PidAccelLast && id <= pic_pkg::PidUplinkLast) begin
      link_pulse = 1'b1;
      link_adm   = pulse_i.uplink_enable && ((c13 & pic_pkg::C13Xlink) == '0);
    end else if (id > pic_pkg::PidUplinkLast && id <= pic_pkg::PidXlinkLast) begin
      link_pulse = 1'b1;
      link_adm   = (c13 & pic_pkg::C13Xlink) != '0;
    end
  end

  // Request decode and precounter update
  always_comb begin
    result_o   = '0;
    precount_o = precount_i;
    priority if (id <= pic_pkg::PidAngleLast) begin
      result_o.count_valid = 1'b1;
      result_o.counter_sel = id[4:1];
      result_o.count_kind  = odd ? pic_pkg::KindMinus : pic_pkg::KindPlus;
    end else if (id <= pic_pkg::PidAccelLast) begin
      result_o.accel_seen_axis  = axis + 2'd1;
      result_o.accel_seen_minus = odd;
      if (!odd) begin
        if (pc == pic_pkg::PcTop) begin
          result_o.count_valid = 1'b1;
          result_o.counter_sel = pic_pkg::SelAccelBase + {2'b00, axis};
          result_o.count_kind  = pic_pkg::KindPlus;
        end else begin
          precount_o[axis] = pc + 2'd1;
        end
      end else begin
        if (pc == pic_pkg::PcBottom) begin
          result_o.count_valid = 1'b1;
          result_o.counter_sel = pic_pkg::SelAccelBase + {2'b00, axis};
          result_o.count_kind  = pic_pkg::KindMinus;
        end else begin
          precount_o[axis] = pc - 2'd1;
        end
      end
    end else if (link_pulse) begin
      // too-fast wins over inhibit
      if (link_adm) begin
        if (pulse_i.uplink_too_fast) begin
          result_o.clear_ch33 = 1'b1;
        end else if ((c13 & pic_pkg::C13Inhibit) == '0) begin
          result_o.count_valid = 1'b1;
          result_o.counter_sel = pic_pkg::SelInlink;
          result_o.count_kind  = link_kind;
        end
      end
    end else if (id <= pic_pkg::PidLrLast) begin
      if ((c13 & pic_pkg::C13LrBoth) == pic_pkg::C13LrBoth) begin
        result_o.count_valid = 1'b1;
        result_o.counter_sel = pic_pkg::SelRadar;
        result_o.count_kind  = link_kind;
      end
    end else if (id <= pic_pkg::PidRrLast) begin
      if (((c13 & pic_pkg::C13RadarEn) != '0) && ((c13 & pic_pkg::C13RrSel) != '0)) begin
        result_o.count_valid = 1'b1;
        result_o.counter_sel = pic_pkg::SelRadar;
        result_o.count_kind  = link_kind;
      end
    end else if (id == pic_pkg::PidDownlinkEnd) begin
      result_o.downrupt_request = 1'b1;
    end else begin
      result_o = '0;
    end
  end

endmodule

`default_nettype wire
